@@ hw/rtl/qasp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasp_pkg
// shared types, codes and constants of the axis speed controller
// ----------------------------------------------------------------------------
package qasp_pkg;

   localparam int DIV_W = 44;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int ACC_W = 42;

   localparam int SPEED_MIN_DEF     = 20;
   localparam int PWM_INIT_DEF      = 128;
   localparam int PWM_MIN_DEF       = 0;
   localparam int PWM_MAX_DEF       = 255;
   localparam int STEP_DISTANCE_DEF = 100000;

   localparam logic [1:0] OP_EDGE   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_SETPOS = 2'd2;

   localparam logic [1:0] DIR_IDLE   = 2'd0;
   localparam logic [1:0] DIR_LOWER  = 2'd1;
   localparam logic [1:0] DIR_HIGHER = 2'd2;

   localparam logic [1:0] FLT_NONE = 2'd0;
   localparam logic [1:0] FLT_LOW  = 2'd1;
   localparam logic [1:0] FLT_HIGH = 2'd2;

   localparam logic [2:0] REG_BOUND_LOW  = 3'd0;
   localparam logic [2:0] REG_BOUND_HIGH = 3'd1;
   localparam logic [2:0] REG_SLOPE      = 3'd2;
   localparam logic [2:0] REG_DRAW_MAX   = 3'd3;
   localparam logic [2:0] REG_QUICK_MAX  = 3'd4;
   localparam logic [2:0] REG_GAIN_P     = 3'd5;
   localparam logic [2:0] REG_GAIN_I     = 3'd6;
   localparam logic [2:0] REG_GAIN_D     = 3'd7;

   typedef struct packed {
      logic signed [15:0] bound_low;
      logic signed [15:0] bound_high;
      logic [15:0]        speed_slope;
      logic [15:0]        speed_draw_max;
      logic [15:0]        speed_quick_max;
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [23:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIST, S_GMUL, S_GOAL, S_DIV, S_ERR, S_MP, S_MD, S_MI,
      S_MACC, S_PWM, S_KICK, S_DRIVE, S_DONE
   } state_type;

endpackage

@@ hw/rtl/qasp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasp_req_if / qasp_rsp_if
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface qasp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [1:0]         phase;
   logic [23:0]        elapsed_us;
   logic signed [15:0] target;
   logic               quick_move;
   modport source (output valid, opcode, phase, elapsed_us, target, quick_move, input ready);
   modport sink (input valid, opcode, phase, elapsed_us, target, quick_move, output ready);
endinterface

interface qasp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         drive_side;
   logic [7:0]         pwm_level;
   logic signed [15:0] position_now;
   logic [15:0]        speed_goal;
   logic [15:0]        speed_seen;
   logic [1:0]         fault;
   logic               moving;
   modport source (output valid, drive_side, pwm_level, position_now, speed_goal,
                   speed_seen, fault, moving, input ready);
   modport sink (input valid, drive_side, pwm_level, position_now, speed_goal,
                 speed_seen, fault, moving, output ready);
endinterface

@@ hw/rtl/qasp_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasp_csr
// configuration register bank on an apb-style port
// ----------------------------------------------------------------------------
module qasp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output qasp_pkg::cfg_type cfg
);
   import qasp_pkg::*;

   logic [15:0] regs_ff [8];
   logic [2:0]  idx;
   logic        wr;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, regs_ff[idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_BOUND_LOW]  <= 16'hF060;
         regs_ff[REG_BOUND_HIGH] <= 16'd4000;
         regs_ff[REG_SLOPE]      <= 16'd256;
         regs_ff[REG_DRAW_MAX]   <= 16'd200;
         regs_ff[REG_QUICK_MAX]  <= 16'd1000;
         regs_ff[REG_GAIN_P]     <= 16'd256;
         regs_ff[REG_GAIN_I]     <= 16'd0;
         regs_ff[REG_GAIN_D]     <= 16'd0;
      end else if (wr) begin
         regs_ff[idx] <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      cfg.bound_low       = regs_ff[REG_BOUND_LOW];
      cfg.bound_high      = regs_ff[REG_BOUND_HIGH];
      cfg.speed_slope     = regs_ff[REG_SLOPE];
      cfg.speed_draw_max  = regs_ff[REG_DRAW_MAX];
      cfg.speed_quick_max = regs_ff[REG_QUICK_MAX];
      cfg.gain_p          = regs_ff[REG_GAIN_P];
      cfg.gain_i          = regs_ff[REG_GAIN_I];
      cfg.gain_d          = regs_ff[REG_GAIN_D];
   end

endmodule

@@ hw/rtl/qasp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasp_div
// bit-serial restoring divider of a fixed dividend, saturated 16-bit quotient
// ----------------------------------------------------------------------------
module qasp_div #(
   parameter logic [qasp_pkg::DIV_W-1:0] DIVIDEND = '1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  qasp_pkg::div_req_type div_req,
   output qasp_pkg::div_rsp_type div_rsp
);
   import qasp_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [23:0]      rem_ff;
   logic [23:0]      dvs_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [24:0]      trial;
   logic [24:0]      diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvs_ff  <= div_req.divisor;
            quo_ff  <= DIVIDEND;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[23:0] : trial[23:0];
            quo_ff <= {quo_ff[DIV_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      div_rsp.done     = done_ff;
      div_rsp.quotient = (|quo_ff[DIV_W-1:16]) ? 16'hFFFF : quo_ff[15:0];
   end

endmodule

@@ hw/rtl/qasp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasp_core
// position tracking, speed ramp and incremental pid on one shared multiplier
// ----------------------------------------------------------------------------
module qasp_core #(
   parameter int SPEED_MIN     = qasp_pkg::SPEED_MIN_DEF,
   parameter int PWM_INIT      = qasp_pkg::PWM_INIT_DEF,
   parameter int PWM_MIN       = qasp_pkg::PWM_MIN_DEF,
   parameter int PWM_MAX       = qasp_pkg::PWM_MAX_DEF,
   parameter int STEP_DISTANCE = qasp_pkg::STEP_DISTANCE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  qasp_pkg::cfg_type cfg,
   qasp_req_if.sink          req_ch,
   qasp_rsp_if.source        rsp_ch
);
   import qasp_pkg::*;

   localparam logic [DIV_W-1:0] DIVIDEND =
      DIV_W'(STEP_DISTANCE) * DIV_W'(1000000);
   localparam logic [7:0] P_MIN  = 8'(PWM_MIN);
   localparam logic [7:0] P_MAX  = 8'(PWM_MAX);
   localparam logic [7:0] P_INIT = (PWM_INIT < PWM_MIN) ? 8'(PWM_MIN) :
                                   (PWM_INIT > PWM_MAX) ? 8'(PWM_MAX) : 8'(PWM_INIT);

   state_type state_ff, state_in;

   logic signed [15:0] pos_ff, goal_pos_ff;
   logic [1:0]         last_phase_ff, dir_ff, fault_ff;
   logic               quick_ff, kick_ff;
   logic signed [17:0] prev_ff, err_ff, derr_ff;
   logic signed [23:0] esum_ff;
   logic [7:0]         pwm_ff;
   logic [23:0]        elapsed_ff;
   logic [16:0]        dist_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff;
   logic [15:0]        goal_ff, seen_ff;
   logic [1:0]         side_ff;
   logic [7:0]         lvl_ff;

   logic               rsp_valid_ff;
   logic [1:0]         o_side_ff, o_fault_ff;
   logic [7:0]         o_pwm_ff;
   logic signed [15:0] o_pos_ff;
   logic [15:0]        o_goal_ff, o_seen_ff;
   logic               o_moving_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               accept, load_out;
   logic               step_up;
   logic signed [16:0] pos_step;
   logic signed [15:0] pos_new;
   logic [1:0]         fault_new;
   logic [1:0]         dir_start;
   logic signed [16:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [ACC_W-1:0] mul_p;
   logic signed [16:0] dist_diff;
   logic [25:0]        goal_sum;
   logic [15:0]        ceil_v;
   logic signed [17:0] e_v, de_v;
   logic signed [24:0] sum_v;
   logic signed [34:0] pwm_sum;

   qasp_div #(.DIVIDEND(DIVIDEND)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_ch.opcode == OP_EDGE && fault_new == FLT_NONE) begin
                  state_in = S_DIST;
               end else if (req_ch.opcode == OP_START && fault_ff == FLT_NONE &&
                            dir_start != DIR_IDLE) begin
                  state_in = S_DIST;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DIST:  state_in = S_GMUL;
         S_GMUL:  state_in = S_GOAL;
         S_GOAL:  state_in = kick_ff ? S_KICK : S_DIV;
         S_DIV:   state_in = div_rsp.done ? S_ERR : S_DIV;
         S_ERR:   state_in = S_MP;
         S_MP:    state_in = S_MD;
         S_MD:    state_in = S_MI;
         S_MI:    state_in = S_MACC;
         S_MACC:  state_in = S_PWM;
         S_PWM:   state_in = S_DRIVE;
         S_KICK:  state_in = S_DRIVE;
         S_DRIVE: state_in = S_DONE;
         S_DONE:  state_in = load_out ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready    = state_ff == S_IDLE;
      load_out        = state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready);
      div_req.start   = state_ff == S_GOAL && !kick_ff;
      div_req.divisor = elapsed_ff;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_GMUL: begin
            mul_a = {1'b0, cfg.speed_slope};
            mul_b = {8'd0, dist_ff};
         end
         S_MP: begin
            mul_a = 17'(cfg.gain_p);
            mul_b = 25'(err_ff);
         end
         S_MD: begin
            mul_a = 17'(cfg.gain_d);
            mul_b = 25'(derr_ff);
         end
         S_MI: begin
            mul_a = 17'(cfg.gain_i);
            mul_b = 25'(esum_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign mul_p  = ACC_W'(mul_a) * ACC_W'(mul_b);

   // position step, bound check and start direction
   always_comb begin
      step_up  = 2'(req_ch.phase - last_phase_ff) == 2'd1;
      pos_step = 17'(pos_ff) + (step_up ? 17'sd1 : -17'sd1);
      if (pos_step > 17'sd32767) begin
         pos_new = 16'sh7FFF;
      end else if (pos_step < -17'sd32768) begin
         pos_new = 16'sh8000;
      end else begin
         pos_new = pos_step[15:0];
      end
      fault_new = fault_ff;
      if (fault_ff == FLT_NONE) begin
         if (pos_new < cfg.bound_low) begin
            fault_new = FLT_LOW;
         end else if (pos_new > cfg.bound_high) begin
            fault_new = FLT_HIGH;
         end
      end
      if (pos_ff > req_ch.target) begin
         dir_start = DIR_LOWER;
      end else if (pos_ff < req_ch.target) begin
         dir_start = DIR_HIGHER;
      end else begin
         dir_start = DIR_IDLE;
      end
   end

   always_comb begin
      dist_diff = 17'(goal_pos_ff) - 17'(pos_ff);
      goal_sum  = 26'(SPEED_MIN) + 26'(prod_ff[32:8]);
      ceil_v    = quick_ff ? cfg.speed_quick_max : cfg.speed_draw_max;
      e_v       = $signed({2'b00, goal_ff}) - $signed({2'b00, seen_ff});
      de_v      = e_v - prev_ff;
      sum_v     = 25'(esum_ff) + 25'(e_v);
      pwm_sum   = 35'($signed(acc_ff[ACC_W-1:8])) + $signed({27'd0, pwm_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         last_phase_ff <= '0;
         goal_pos_ff   <= '0;
         dir_ff        <= DIR_IDLE;
         quick_ff      <= 1'b0;
         kick_ff       <= 1'b0;
         prev_ff       <= '0;
         esum_ff       <= '0;
         pwm_ff        <= '0;
         fault_ff      <= FLT_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  elapsed_ff <= req_ch.elapsed_us;
                  goal_ff    <= '0;
                  seen_ff    <= '0;
                  side_ff    <= dir_ff;
                  lvl_ff     <= (dir_ff != DIR_IDLE) ? pwm_ff : 8'd0;
                  case (req_ch.opcode)
                     OP_EDGE: begin
                        pos_ff        <= pos_new;
                        last_phase_ff <= req_ch.phase;
                        fault_ff      <= fault_new;
                        if (fault_new != FLT_NONE) begin
                           dir_ff  <= DIR_IDLE;
                           side_ff <= DIR_IDLE;
                           lvl_ff  <= 8'd0;
                        end
                     end
                     OP_START: begin
                        if (fault_ff == FLT_NONE) begin
                           goal_pos_ff <= req_ch.target;
                           quick_ff    <= req_ch.quick_move;
                           kick_ff     <= 1'b1;
                           dir_ff      <= dir_start;
                           side_ff     <= DIR_IDLE;
                           lvl_ff      <= 8'd0;
                        end
                     end
                     OP_SETPOS: begin
                        pos_ff <= req_ch.target;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_DIST: begin
               dist_ff <= dist_diff[16] ? 17'(-dist_diff) : 17'(dist_diff);
            end
            S_GMUL: prod_ff <= mul_p;
            S_GOAL: begin
               goal_ff <= (goal_sum > 26'(ceil_v)) ? ceil_v : goal_sum[15:0];
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  seen_ff <= div_rsp.quotient;
               end
            end
            S_ERR: begin
               err_ff  <= e_v;
               derr_ff <= de_v;
               prev_ff <= e_v;
               if (sum_v[24] != sum_v[23]) begin
                  esum_ff <= sum_v[24] ? 24'sh800000 : 24'sh7FFFFF;
               end else begin
                  esum_ff <= sum_v[23:0];
               end
            end
            S_MP: prod_ff <= mul_p;
            S_MD: begin
               acc_ff  <= prod_ff;
               prod_ff <= mul_p;
            end
            S_MI: begin
               acc_ff  <= acc_ff + prod_ff;
               prod_ff <= mul_p;
            end
            S_MACC: acc_ff <= acc_ff + prod_ff;
            S_PWM: begin
               if (pwm_sum < $signed({27'd0, P_MIN})) begin
                  pwm_ff <= P_MIN;
               end else if (pwm_sum > $signed({27'd0, P_MAX})) begin
                  pwm_ff <= P_MAX;
               end else begin
                  pwm_ff <= pwm_sum[7:0];
               end
            end
            S_KICK: begin
               prev_ff <= '0;
               esum_ff <= '0;
               pwm_ff  <= P_INIT;
               seen_ff <= goal_ff;
               kick_ff <= 1'b0;
            end
            S_DRIVE: begin
               if (dir_ff == DIR_LOWER && pos_ff > goal_pos_ff) begin
                  side_ff <= DIR_LOWER;
                  lvl_ff  <= pwm_ff;
               end else if (dir_ff == DIR_HIGHER && pos_ff < goal_pos_ff) begin
                  side_ff <= DIR_HIGHER;
                  lvl_ff  <= pwm_ff;
               end else begin
                  side_ff  <= DIR_IDLE;
                  lvl_ff   <= 8'd0;
                  quick_ff <= 1'b0;
                  dir_ff   <= DIR_IDLE;
               end
            end
            S_DONE: begin
               if (load_out) begin
                  o_side_ff    <= side_ff;
                  o_pwm_ff     <= lvl_ff;
                  o_pos_ff     <= pos_ff;
                  o_goal_ff    <= goal_ff;
                  o_seen_ff    <= seen_ff;
                  o_fault_ff   <= fault_ff;
                  o_moving_ff  <= dir_ff != DIR_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_ch.valid        = rsp_valid_ff;
      rsp_ch.drive_side   = o_side_ff;
      rsp_ch.pwm_level    = o_pwm_ff;
      rsp_ch.position_now = o_pos_ff;
      rsp_ch.speed_goal   = o_goal_ff;
      rsp_ch.speed_seen   = o_seen_ff;
      rsp_ch.fault        = o_fault_ff;
      rsp_ch.moving       = o_moving_ff;
   end

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff != FLT_NONE |=> $stable(fault_ff))
      else $error("fault latch changed");

   a_drive_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_side_ff != DIR_IDLE |-> o_fault_ff == FLT_NONE && o_moving_ff)
      else $error("drive with fault or idle axis");

   a_div_to_err: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_rsp.done |=> state_ff == S_ERR)
      else $error("divider result not consumed");

endmodule

@@ hw/rtl/quadrature_axis_speed_pid_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_axis_speed_pid_top
// dc-motor axis controller with quadrature position and pid speed loop
// ----------------------------------------------------------------------------
// One item at a time. A sensor edge that runs the pid passes distance,
// speed ramp, speed goal, the bit-serial speed divider (one quotient bit
// per cycle over a 44-bit dividend), error, the three gain terms on one
// shared 17x25 multiplier that also forms the ramp, accumulate, pwm and
// drive. A move-start kickoff does a kick step after the speed goal;
// set-position, ignored and fault items go straight to the result. New
// items wait for the result register, and it for the receiver to drain.
module quadrature_axis_speed_pid_top #(
   parameter int SPEED_MIN     = qasp_pkg::SPEED_MIN_DEF,
   parameter int PWM_INIT      = qasp_pkg::PWM_INIT_DEF,
   parameter int PWM_MIN       = qasp_pkg::PWM_MIN_DEF,
   parameter int PWM_MAX       = qasp_pkg::PWM_MAX_DEF,
   parameter int STEP_DISTANCE = qasp_pkg::STEP_DISTANCE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   qasp_req_if.sink    req_ch,
   qasp_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import qasp_pkg::*;

   cfg_type cfg;

   qasp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qasp_core #(
      .SPEED_MIN     (SPEED_MIN),
      .PWM_INIT      (PWM_INIT),
      .PWM_MIN       (PWM_MIN),
      .PWM_MAX       (PWM_MAX),
      .STEP_DISTANCE (STEP_DISTANCE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
